FILE: hw/rtl/rsrf_pkg.sv
package rsrf_pkg;

   // Queue geometry
   localparam int CAPACITY       = 64;
   localparam int RESERVED_SLOTS = 4;
   localparam int PAYLOAD_BITS   = 32;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   // compare width: covers the fill count, the 6-bit offset and the 7-bit fill port
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
   localparam int SUM_W = CMP_W + 1;

   // samples are refused once the fill reaches this level
   localparam int SAMPLE_LIMIT = (RESERVED_SLOTS >= CAPACITY) ? 0 : CAPACITY - RESERVED_SLOTS;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_READ   = 2'd1,
      OP_COMMIT = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_STORED      = 3'd0,
      ST_SAMPLE_DROP = 3'd1,
      ST_CRIT_DROP   = 3'd2,
      ST_READ_OK     = 3'd3,
      ST_READ_EMPTY  = 3'd4,
      ST_PENDING     = 3'd5,
      ST_COMMITTED   = 3'd6,
      ST_REJECTED    = 3'd7
   } status_type;

   typedef struct packed {
      op_type      opcode;
      logic [1:0]  rec_kind;
      logic [31:0] rec_seq;
      logic [31:0] rec_uptime;
      logic [31:0] rec_payload;
      logic [5:0]  offset;
      logic        last;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [1:0]  out_kind;
      logic [31:0] out_seq;
      logic [31:0] out_uptime;
      logic [31:0] out_payload;
      logic [6:0]  fill_count;
      logic [31:0] samples_dropped;
      logic [31:0] critical_dropped;
   } rsp_type;

   // one stored record
   typedef struct packed {
      logic [1:0]              kind;
      logic [31:0]             seq;
      logic [31:0]             uptime;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic execute;
   } cmd_type;

   // slot of position pos from base; valid while base + pos < 2 * CAPACITY
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [CMP_W-1:0] pos);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(pos);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/rsrf_ram.sv
module rsrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/rsrf_ctrl.sv
module rsrf_ctrl
   import rsrf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // idle takes a request and starts the entry read; exec finishes it
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff == S_EXEC);
   assign cmd.load    = start && (state_ff == S_IDLE);
   assign cmd.execute = (state_ff == S_EXEC);

endmodule

FILE: hw/rtl/rsrf_datapath.sv
module rsrf_datapath
   import rsrf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   req_type          req_ff;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      sdrop_ff, sdrop_in;
   logic [31:0]      cdrop_ff, cdrop_in;
   logic [CNT_W-1:0] cpos_ff, cpos_in;
   logic             cmatch_ff, cmatch_in;
   rsp_type          rsp_ff, rsp_in;
   logic             strobe_ff;

   entry_type        rd_entry, wr_entry;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             wr_en;
   logic [CMP_W-1:0] pos_cmp;
   logic             in_fill;
   logic             match;
   logic             all_match;
   logic [CNT_W-1:0] prefix_len;
   logic [63:0]      pay_wide, out_pay_wide;

   // entry read starts with the request: slot of offset or of commit position
   always_comb begin
      if (req_data.opcode == OP_READ) begin
         rd_addr = wrap_add(head_ff, CMP_W'(req_data.offset));
      end else begin
         rd_addr = wrap_add(head_ff, CMP_W'(cpos_ff));
      end
   end

   // record store
   assign pay_wide          = 64'(req_ff.rec_payload);
   assign wr_entry.kind     = req_ff.rec_kind;
   assign wr_entry.seq      = req_ff.rec_seq;
   assign wr_entry.uptime   = req_ff.rec_uptime;
   assign wr_entry.payload  = pay_wide[PAYLOAD_BITS-1:0];
   assign wr_addr           = wrap_add(head_ff, CMP_W'(count_ff));

   rsrf_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (cmd.load),
      .rd_addr(rd_addr),
      .rd_data(rd_entry)
   );

   // position checks against the fill
   assign pos_cmp      = (req_ff.opcode == OP_READ) ? CMP_W'(req_ff.offset) : CMP_W'(cpos_ff);
   assign in_fill      = pos_cmp < CMP_W'(count_ff);
   assign match        = in_fill && (rd_entry.kind == req_ff.rec_kind)
                         && (rd_entry.seq == req_ff.rec_seq)
                         && (rd_entry.uptime == req_ff.rec_uptime);
   assign all_match    = cmatch_ff && match;
   assign prefix_len   = cpos_ff + CNT_W'(1);
   assign out_pay_wide = 64'(rd_entry.payload);

   // execute the latched request
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      sdrop_in  = sdrop_ff;
      cdrop_in  = cdrop_ff;
      cpos_in   = cpos_ff;
      cmatch_in = cmatch_ff;
      wr_en     = 1'b0;
      rsp_in    = '0;
      rsp_in.status = ST_REJECTED;

      case (req_ff.opcode)
         OP_PUSH: begin
            if ((req_ff.rec_kind == 2'd0) && (count_ff >= CNT_W'(SAMPLE_LIMIT))) begin
               sdrop_in      = sdrop_ff + 32'd1;
               rsp_in.status = ST_SAMPLE_DROP;
            end else if (count_ff == CNT_W'(CAPACITY)) begin
               cdrop_in      = cdrop_ff + 32'd1;
               rsp_in.status = ST_CRIT_DROP;
            end else begin
               wr_en         = cmd.execute;
               count_in      = count_ff + CNT_W'(1);
               rsp_in.status = ST_STORED;
            end
         end
         OP_READ: begin
            if (in_fill) begin
               rsp_in.status      = ST_READ_OK;
               rsp_in.out_kind    = rd_entry.kind;
               rsp_in.out_seq     = rd_entry.seq;
               rsp_in.out_uptime  = rd_entry.uptime;
               rsp_in.out_payload = out_pay_wide[31:0];
            end else begin
               rsp_in.status = ST_READ_EMPTY;
            end
         end
         OP_COMMIT: begin
            if (req_ff.last) begin
               if (all_match) begin
                  head_in       = wrap_add(head_ff, CMP_W'(prefix_len));
                  count_in      = count_ff - prefix_len;
                  rsp_in.status = ST_COMMITTED;
               end else begin
                  rsp_in.status = ST_REJECTED;
               end
               cpos_in   = '0;
               cmatch_in = 1'b1;
            end else begin
               if (cpos_ff < CNT_W'(CAPACITY)) begin
                  cpos_in = prefix_len;
               end
               cmatch_in     = all_match;
               rsp_in.status = ST_PENDING;
            end
         end
         default: rsp_in.status = ST_REJECTED;
      endcase

      rsp_in.fill_count       = 7'(count_in);
      rsp_in.samples_dropped  = sdrop_in;
      rsp_in.critical_dropped = cdrop_in;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   // queue state and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         sdrop_ff  <= '0;
         cdrop_ff  <= '0;
         cpos_ff   <= '0;
         cmatch_ff <= 1'b1;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.execute;
         if (cmd.execute) begin
            head_ff   <= head_in;
            count_ff  <= count_in;
            sdrop_ff  <= sdrop_in;
            cdrop_ff  <= cdrop_in;
            cpos_ff   <= cpos_in;
            cmatch_ff <= cmatch_in;
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: hw/rtl/reserved_slot_record_fifo_top.sv
// Record FIFO with reserved slots for non-sample records.
// A request taken while idle is latched and its store entry read; the update state then
// registers its result, shown for one cycle and marked by rsp_strobe on the rsp_ ports.
// A new request is taken only while idle, not in the update state after the registered
// read of the record store; the receiver cannot stall the result.
// Reset (synchronous): clears head, fill, drop counters and commit state; no store sweep.
module reserved_slot_record_fifo_top
   import rsrf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   cmd_type cmd;

   rsrf_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .cmd  (cmd)
   );

   rsrf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hw/rtl/rsrf_checker.sv
module rsrf_checker
   import rsrf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // a taken request keeps the block busy for its update cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   // every update cycle yields exactly one result right after
   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_strobe && !busy))
      else $error("update cycle without a result");

   // a result only follows a request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a request");

   // data fields are zero unless an entry was read
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != ST_READ_OK)) |->
         ((rsp_data.out_kind == 2'd0) && (rsp_data.out_seq == 32'd0)
          && (rsp_data.out_uptime == 32'd0) && (rsp_data.out_payload == 32'd0)))
      else $error("data fields set on a result that read nothing");

   // fill never exceeds capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (CMP_W'(rsp_data.fill_count) <= CMP_W'(CAPACITY)))
      else $error("fill count above capacity");

endmodule

bind reserved_slot_record_fifo_top rsrf_checker u_checker (.*);
